// ===== rtl/core/mvte_pkg.sv =====
// MSI-X vector table emulator: shared types and constants.
// No dependencies; used by the top level and the checker under rtl/core.
package mvte_pkg;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam logic REG_NUM_ENTRIES = 1'b0;
  localparam logic REG_PRIV_OWNER  = 1'b1;

  localparam logic [63:0] ALL_ONES = ~64'd0;

  typedef enum logic [1:0] {
    FUNC_TBL_RD  = 2'd0,
    FUNC_TBL_WR  = 2'd1,
    FUNC_CTRL_RD = 2'd2,
    FUNC_CTRL_WR = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    KIND_DONE    = 3'd0,
    KIND_DISABLE = 3'd1,
    KIND_PROGRAM = 3'd2,
    KIND_SETMASK = 3'd3,
    KIND_INTX    = 3'd4
  } kind_t;

  localparam logic [3:0] WORD_ADDR_LO = 4'd0;
  localparam logic [3:0] WORD_ADDR_HI = 4'd4;
  localparam logic [3:0] WORD_DATA    = 4'd8;
  localparam logic [3:0] WORD_CTRL    = 4'd12;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_TBL_RD,
    ST_TBL_WR,
    ST_WALK,
    ST_WALK_PROG,
    ST_CTRL_END,
    ST_DONE
  } state_t;

  typedef struct packed {
    func_t       func;
    logic [8:0]  byte_offset;
    logic        wide_access;
    logic        size_valid;
    logic [63:0] write_data;
  } in_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [4:0]  entry_index;
    logic [63:0] msg_address;
    logic [31:0] msg_data;
    logic        mask_bit;
    logic [63:0] read_data;
    logic        last;
  } out_item_t;

endpackage

// ===== rtl/core/mvte_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
module mvte_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                      wdata,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ===== rtl/core/msix_vector_table_emulator_unit.sv =====
// MSI-X vector table emulator top level: table RAM, entry flags, control FSM.
// Depends on mvte_pkg and mvte_ram.
// A control read, an unchanged control write or a rejected access completes from the
// decode state; a table read goes through a RAM read, a table write through one RAM
// read-modify-write. A changed control word may walk the n implemented entries and
// reprogram some of them. One access at a time: busy drops with the completion beat
// and the next start is taken in that cycle. Sync reset clears the control state and
// flags and sets the mask bits; unwritten entries read as zero via per-entry valid bits.
module msix_vector_table_emulator_unit #(
  parameter int TABLE_SLOTS = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  mvte_pkg::in_item_t         item,
  output logic                       result_valid,
  output mvte_pkg::out_item_t        result,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mvte_pkg::CFG_AW-1:0] paddr,
  input  logic [mvte_pkg::CFG_DW-1:0] pwdata,
  output logic [mvte_pkg::CFG_DW-1:0] prdata,
  output logic                       pready
);

  localparam int DEPTH   = TABLE_SLOTS < 32 ? TABLE_SLOTS : 32;
  localparam int IW      = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int ENTRY_W = 96;
  localparam logic [6:0] CAP = 7'(DEPTH);

  // config
  logic [5:0] num_entries;
  logic       privileged_owner;

  // control
  mvte_pkg::state_t state, state_next;
  mvte_pkg::in_item_t cur, cur_next;
  logic [DEPTH-1:0] masked, masked_next;
  logic [DEPTH-1:0] changed, changed_next;
  logic [DEPTH-1:0] bound, bound_next;
  logic [DEPTH-1:0] valid, valid_next;
  logic fe, fe_next;
  logic fm, fm_next;
  logic walk_prog, walk_prog_next;
  logic [IW:0] widx, widx_next;
  logic res_valid_next;
  mvte_pkg::out_item_t res_next;

  // RAM
  logic               ram_en, ram_we;
  logic [IW-1:0]      ram_addr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

  mvte_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_table (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // APB
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_entries      <= 6'd32;
      privileged_owner <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        mvte_pkg::REG_NUM_ENTRIES: num_entries      <= pwdata[5:0];
        mvte_pkg::REG_PRIV_OWNER:  privileged_owner <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      mvte_pkg::REG_NUM_ENTRIES: prdata = {26'd0, num_entries};
      mvte_pkg::REG_PRIV_OWNER:  prdata = {31'd0, privileged_owner};
      default:                   prdata = '0;
    endcase
  end

  // decode helpers
  logic [6:0]   n;
  logic [4:0]   ei;
  logic [3:0]   w;
  logic [IW-1:0] aidx, wi;
  logic         ok, nm, ne, nmb, chg, mask_req;
  logic [ENTRY_W-1:0] ent, went;
  logic [63:0]  a_new, rd_v, wd_eff;
  logic [31:0]  d_new;

  assign n    = (num_entries == 6'd0) ? 7'd1 :
                (({1'b0, num_entries} > CAP) ? CAP : {1'b0, num_entries});
  assign ei   = cur.byte_offset[8:4];
  assign w    = cur.byte_offset[3:0];
  assign aidx = ei[IW-1:0];
  assign wi   = widx[IW-1:0];
  assign ok   = cur.size_valid &&
                (cur.wide_access ? (cur.byte_offset[2:0] == 3'd0)
                                 : (cur.byte_offset[1:0] == 2'd0)) &&
                ({2'b00, ei} < n);
  assign nm   = cur.write_data[14];
  assign ne   = cur.write_data[15];
  assign ent  = valid[aidx] ? ram_rdata : '0;
  assign went = valid[wi] ? ram_rdata : '0;
  assign wd_eff = cur.wide_access ? cur.write_data : {32'd0, cur.write_data[31:0]};

  always_comb begin
    a_new = ent[63:0];
    d_new = ent[95:64];
    case (w)
      mvte_pkg::WORD_ADDR_LO: a_new = cur.wide_access ? wd_eff : {ent[63:32], wd_eff[31:0]};
      mvte_pkg::WORD_ADDR_HI: a_new = {wd_eff[31:0], ent[31:0]};
      mvte_pkg::WORD_DATA:    d_new = wd_eff[31:0];
      default: ;
    endcase
  end

  always_comb begin
    case (w)
      mvte_pkg::WORD_ADDR_LO: rd_v = ent[63:0];
      mvte_pkg::WORD_ADDR_HI: rd_v = {32'd0, ent[63:32]};
      mvte_pkg::WORD_DATA:    rd_v = {31'd0, cur.wide_access && masked[aidx], ent[95:64]};
      default:                rd_v = {63'd0, masked[aidx]};
    endcase
    if (!cur.wide_access) begin
      rd_v = {32'd0, rd_v[31:0]};
    end
  end

  assign mask_req = (w == mvte_pkg::WORD_CTRL) ||
                    ((w == mvte_pkg::WORD_DATA) && cur.wide_access);
  assign nmb      = (w == mvte_pkg::WORD_CTRL) ? wd_eff[0] : wd_eff[32];
  assign chg      = (w != mvte_pkg::WORD_CTRL) || changed[aidx];

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= mvte_pkg::ST_IDLE;
      masked       <= '1;
      changed      <= '0;
      bound        <= '0;
      valid        <= '0;
      fe           <= 1'b0;
      fm           <= 1'b0;
      walk_prog    <= 1'b0;
      widx         <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      masked       <= masked_next;
      changed      <= changed_next;
      bound        <= bound_next;
      valid        <= valid_next;
      fe           <= fe_next;
      fm           <= fm_next;
      walk_prog    <= walk_prog_next;
      widx         <= widx_next;
      result_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cur    <= cur_next;
    result <= res_next;
  end

  assign busy = (state != mvte_pkg::ST_IDLE);

  always_comb begin
    state_next     = state;
    cur_next       = cur;
    masked_next    = masked;
    changed_next   = changed;
    bound_next     = bound;
    valid_next     = valid;
    fe_next        = fe;
    fm_next        = fm;
    walk_prog_next = walk_prog;
    widx_next      = widx;
    res_valid_next = 1'b0;
    res_next       = '0;
    ram_en         = 1'b0;
    ram_we         = 1'b0;
    ram_addr       = aidx;
    ram_wdata      = {d_new, a_new};

    unique case (state)
      mvte_pkg::ST_IDLE: begin
        if (start) begin
          cur_next   = item;
          state_next = mvte_pkg::ST_DECODE;
        end
      end

      mvte_pkg::ST_DECODE: begin
        unique case (cur.func)
          mvte_pkg::FUNC_CTRL_RD: begin
            res_valid_next     = 1'b1;
            res_next.kind      = mvte_pkg::KIND_DONE;
            res_next.last      = 1'b1;
            res_next.read_data = {48'd0, fe, fm, 7'd0, 7'(n - 7'd1)};
            state_next         = mvte_pkg::ST_IDLE;
          end
          mvte_pkg::FUNC_TBL_RD, mvte_pkg::FUNC_TBL_WR: begin
            if (ok) begin
              ram_en     = 1'b1;
              state_next = (cur.func == mvte_pkg::FUNC_TBL_RD) ? mvte_pkg::ST_TBL_RD
                                                               : mvte_pkg::ST_TBL_WR;
            end else begin
              res_valid_next     = 1'b1;
              res_next.kind      = mvte_pkg::KIND_DONE;
              res_next.last      = 1'b1;
              res_next.read_data = (cur.func == mvte_pkg::FUNC_TBL_RD) ? mvte_pkg::ALL_ONES
                                                                      : 64'd0;
              state_next         = mvte_pkg::ST_IDLE;
            end
          end
          mvte_pkg::FUNC_CTRL_WR: begin
            if (nm != fm || ne != fe) begin
              walk_prog_next = ne && !nm && (!fe || fm);
              widx_next      = '0;
              state_next     = ((ne && !nm && (!fe || fm)) || (!ne && fe)) ?
                               mvte_pkg::ST_WALK : mvte_pkg::ST_CTRL_END;
            end else begin
              res_valid_next = 1'b1;
              res_next.kind  = mvte_pkg::KIND_DONE;
              res_next.last  = 1'b1;
              state_next     = mvte_pkg::ST_IDLE;
            end
          end
          default: state_next = mvte_pkg::ST_IDLE;
        endcase
      end

      mvte_pkg::ST_TBL_RD: begin
        res_valid_next     = 1'b1;
        res_next.kind      = mvte_pkg::KIND_DONE;
        res_next.last      = 1'b1;
        res_next.read_data = rd_v;
        state_next         = mvte_pkg::ST_IDLE;
      end

      mvte_pkg::ST_TBL_WR: begin
        if (w != mvte_pkg::WORD_CTRL) begin
          ram_en             = 1'b1;
          ram_we             = 1'b1;
          valid_next[aidx]   = 1'b1;
          changed_next[aidx] = 1'b1;
        end
        if (mask_req && (masked[aidx] != nmb)) begin
          masked_next[aidx] = nmb;
          res_valid_next    = 1'b1;
          res_next.entry_index = ei;
          if (!nmb && fe && !fm && chg) begin
            res_next.kind        = mvte_pkg::KIND_PROGRAM;
            res_next.msg_address = a_new;
            res_next.msg_data    = d_new;
            res_next.mask_bit    = 1'b0;
            bound_next[aidx]     = 1'b1;
            changed_next[aidx]   = 1'b0;
          end else begin
            res_next.kind     = mvte_pkg::KIND_SETMASK;
            res_next.mask_bit = nmb;
          end
          state_next = mvte_pkg::ST_DONE;
        end else begin
          res_valid_next = 1'b1;
          res_next.kind  = mvte_pkg::KIND_DONE;
          res_next.last  = 1'b1;
          state_next     = mvte_pkg::ST_IDLE;
        end
      end

      mvte_pkg::ST_WALK: begin
        if (7'(widx) < n) begin
          if (walk_prog) begin
            if (!masked[wi] && changed[wi]) begin
              ram_en     = 1'b1;
              ram_addr   = wi;
              state_next = mvte_pkg::ST_WALK_PROG;
            end else begin
              widx_next = widx + 1'b1;
            end
          end else begin
            if (bound[wi]) begin
              res_valid_next       = 1'b1;
              res_next.kind        = mvte_pkg::KIND_DISABLE;
              res_next.entry_index = 5'(wi);
              bound_next[wi]       = 1'b0;
              changed_next[wi]     = 1'b1;
            end
            widx_next = widx + 1'b1;
          end
        end else begin
          state_next = mvte_pkg::ST_CTRL_END;
        end
      end

      mvte_pkg::ST_WALK_PROG: begin
        res_valid_next       = 1'b1;
        res_next.kind        = mvte_pkg::KIND_PROGRAM;
        res_next.entry_index = 5'(wi);
        res_next.msg_address = went[63:0];
        res_next.msg_data    = went[95:64];
        res_next.mask_bit    = 1'b0;
        bound_next[wi]       = 1'b1;
        changed_next[wi]     = 1'b0;
        widx_next            = widx + 1'b1;
        state_next           = mvte_pkg::ST_WALK;
      end

      mvte_pkg::ST_CTRL_END: begin
        fe_next        = ne;
        fm_next        = nm;
        res_valid_next = 1'b1;
        if (ne && !fe && !privileged_owner) begin
          res_next.kind = mvte_pkg::KIND_INTX;
          state_next    = mvte_pkg::ST_DONE;
        end else begin
          res_next.kind = mvte_pkg::KIND_DONE;
          res_next.last = 1'b1;
          state_next    = mvte_pkg::ST_IDLE;
        end
      end

      mvte_pkg::ST_DONE: begin
        res_valid_next = 1'b1;
        res_next.kind  = mvte_pkg::KIND_DONE;
        res_next.last  = 1'b1;
        state_next     = mvte_pkg::ST_IDLE;
      end

      default: state_next = mvte_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/mvte_checker.sv =====
// Port-level checks for the MSI-X vector table emulator, bound to the top level.
// Depends on mvte_pkg and msix_vector_table_emulator_unit.
module mvte_checker (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input logic                result_valid,
  input mvte_pkg::out_item_t result
);

  // accepted access holds the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after accept");

  // no beat in the cycle after an accept
  a_accept_quiet: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> !result_valid)
    else $error("beat right after accept");

  // completion beat frees the block
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last |-> !busy)
    else $error("busy during completion beat");

  // action beats only while busy
  a_action_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last |-> busy)
    else $error("action beat while idle");

  // last marks exactly the completion
  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((result.kind == mvte_pkg::KIND_DONE) == result.last))
    else $error("last does not match completion kind");

endmodule

bind msix_vector_table_emulator_unit mvte_checker u_mvte_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_valid (result_valid),
  .result       (result)
);
